// ===== hdl/ternary_trit_unpacker_assert.svh =====
// assertion macros shared by the ternary trit unpacker checkers
// expects signals named clock and reset in the scope of each use
`ifndef TERNARY_TRIT_UNPACKER_ASSERT_SVH
`define TERNARY_TRIT_UNPACKER_ASSERT_SVH

// condition holds on every cycle out of reset
`define TTU_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define TTU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ttu_pkg.sv =====
// shared types and constants of the ternary trit unpacker
// no dependencies
package ttu_pkg;

   localparam int DIGITS_PER_BYTE = 5;
   localparam int COUNT_BITS      = 16;
   localparam int MAX_DIGITS      = 5;

   localparam int BYTE_W  = 8;
   localparam int TOTAL_W = 16;
   localparam int TRIT_W  = 2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TRIT_TOTAL = 2'd0;

   typedef logic signed [TRIT_W-1:0] trit_type;

   localparam trit_type TRIT_NEG  = 2'sb11;
   localparam trit_type TRIT_ZERO = 2'sb00;
   localparam trit_type TRIT_POS  = 2'sb01;

   // place values of the digits, least significant first
   localparam logic [BYTE_W-1:0] POW3_TAB [0:MAX_DIGITS-1] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};

   // largest legal byte for k digits
   localparam logic [BYTE_W-1:0] LIMIT_TAB [0:MAX_DIGITS] =
      '{8'd0, 8'd2, 8'd8, 8'd26, 8'd80, 8'd242};

endpackage

// ===== hdl/ttu_if.sv =====
// request and response channels of the ternary trit unpacker
// depends on ttu_pkg
interface ttu_req_if;
   logic                             valid;
   logic                             ready;
   logic [ttu_pkg::BYTE_W-1:0]       packed_byte;
   logic                             block_start;

   modport source (output valid, output packed_byte, output block_start, input ready);
   modport sink   (input valid, input packed_byte, input block_start, output ready);
endinterface

interface ttu_rsp_if;
   logic              valid;
   logic              ready;
   ttu_pkg::trit_type trit;
   logic              last_of_byte;
   logic              block_done;
   logic              bad_byte;

   modport source (output valid, output trit, output last_of_byte, output block_done,
                   output bad_byte, input ready);
   modport sink   (input valid, input trit, input last_of_byte, input block_done,
                   input bad_byte, output ready);
endinterface

// ===== hdl/ternary_trit_unpacker.sv =====
// Ternary trit unpacker: each accepted byte carries k = min(DIGITS_PER_BYTE, trits still
// owed) base-3 digits, most significant first, and yields k signed trits (digit minus one),
// the last one flagged; the trit that completes the configured trit total also carries
// block_done. A byte above 3^k-1 yields one bad_byte beat and mutes the unit until a byte
// with block_start. Bytes arriving once the block is complete or muted yield nothing. Decode
// happens as the byte is accepted; trits drain from a work register into an output register
// one beat per cycle while the output is not stalled, and the next byte is taken in the cycle
// the last trit of the previous one moves to the output register. First trit passes through
// the work register and then the output register. The trit total sits at csr address 0.
module ternary_trit_unpacker #(
   parameter int DIGITS_PER_BYTE = ttu_pkg::DIGITS_PER_BYTE,
   parameter int COUNT_BITS      = ttu_pkg::COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   ttu_req_if.sink                           req_ch,
   ttu_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ttu_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ttu_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ttu_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int NW    = $clog2(DIGITS_PER_BYTE + 1);
   localparam int IDX_W = (DIGITS_PER_BYTE > 1) ? $clog2(DIGITS_PER_BYTE) : 1;
   localparam int TW    = (COUNT_BITS > ttu_pkg::TOTAL_W) ? COUNT_BITS : ttu_pkg::TOTAL_W;

   // configuration
   logic [ttu_pkg::TOTAL_W-1:0] total_ff, total_in;

   // block state
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  err_ff, err_in;

   // work register: trits of the byte still to go out
   logic                   wv_ff, wv_in;
   logic [NW-1:0]          wn_ff, wn_in;
   ttu_pkg::trit_type      wtrit_ff [DIGITS_PER_BYTE];
   ttu_pkg::trit_type      wtrit_in [DIGITS_PER_BYTE];
   logic                   wdone_ff, wdone_in;
   logic                   wbad_ff, wbad_in;

   // output register
   logic              ov_ff, ov_in;
   ttu_pkg::trit_type otrit_ff, otrit_in;
   logic              olast_ff, olast_in;
   logic              odone_ff, odone_in;
   logic              obad_ff, obad_in;

   // decode
   logic                        accept, move, w_last;
   logic [COUNT_BITS-1:0]       cnt_base, tot_eff, remaining;
   logic [TW-1:0]               tot_wide, cmax_wide, tot_sel;
   logic                        err_base, active, bad;
   logic [NW-1:0]               k;
   logic [ttu_pkg::BYTE_W-1:0]  rem;
   ttu_pkg::trit_type           dec_trit [DIGITS_PER_BYTE];
   logic [IDX_W-1:0]            head;
   logic                        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == ttu_pkg::ADDR_TRIT_TOTAL);
   assign csr_prdata = (csr_paddr == ttu_pkg::ADDR_TRIT_TOTAL)
                       ? ttu_pkg::CSR_DATA_W'(total_ff) : '0;
   assign total_in   = csr_wr ? csr_pwdata[ttu_pkg::TOTAL_W-1:0] : total_ff;

   // total saturates at the counter's range
   assign tot_wide  = TW'(total_ff);
   assign cmax_wide = TW'({COUNT_BITS{1'b1}});
   assign tot_sel   = (tot_wide > cmax_wide) ? cmax_wide : tot_wide;
   assign tot_eff   = tot_sel[COUNT_BITS-1:0];

   assign w_last = (wn_ff == NW'(1));
   assign move   = wv_ff && (!ov_ff || rsp_ch.ready);
   assign req_ch.ready = !wv_ff || (move && w_last);
   assign accept = req_ch.valid && req_ch.ready;
   assign head   = IDX_W'(wn_ff - NW'(1));

   always_comb begin
      cnt_base  = req_ch.block_start ? '0 : cnt_ff;
      err_base  = req_ch.block_start ? 1'b0 : err_ff;
      active    = !err_base && (cnt_base < tot_eff);
      remaining = tot_eff - cnt_base;
      k = (remaining < COUNT_BITS'(DIGITS_PER_BYTE)) ? NW'(remaining) : NW'(DIGITS_PER_BYTE);
      bad = req_ch.packed_byte > ttu_pkg::LIMIT_TAB[3'(k)];

      // digit extraction, most significant place first, one compare-subtract per place
      rem = req_ch.packed_byte;
      for (int i = DIGITS_PER_BYTE - 1; i >= 0; i--) begin
         if (rem >= (ttu_pkg::POW3_TAB[i] << 1)) begin
            dec_trit[i] = ttu_pkg::TRIT_POS;
            rem = rem - (ttu_pkg::POW3_TAB[i] << 1);
         end else if (rem >= ttu_pkg::POW3_TAB[i]) begin
            dec_trit[i] = ttu_pkg::TRIT_ZERO;
            rem = rem - ttu_pkg::POW3_TAB[i];
         end else begin
            dec_trit[i] = ttu_pkg::TRIT_NEG;
         end
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      wv_in    = wv_ff;
      wn_in    = wn_ff;
      wtrit_in = wtrit_ff;
      wdone_in = wdone_ff;
      wbad_in  = wbad_ff;
      if (accept) begin
         cnt_in   = cnt_base + ((active && !bad) ? COUNT_BITS'(k) : '0);
         err_in   = err_base || (active && bad);
         wv_in    = active;
         wn_in    = bad ? NW'(1) : k;
         wtrit_in = dec_trit;
         wdone_in = (remaining == COUNT_BITS'(k));
         wbad_in  = bad;
      end else if (move) begin
         if (w_last) begin
            wv_in = 1'b0;
         end else begin
            wn_in = wn_ff - NW'(1);
         end
      end
   end

   always_comb begin
      ov_in    = ov_ff;
      otrit_in = otrit_ff;
      olast_in = olast_ff;
      odone_in = odone_ff;
      obad_in  = obad_ff;
      if (move) begin
         ov_in    = 1'b1;
         otrit_in = wbad_ff ? ttu_pkg::TRIT_ZERO : wtrit_ff[head];
         olast_in = w_last;
         odone_in = w_last && wdone_ff && !wbad_ff;
         obad_in  = wbad_ff;
      end else if (rsp_ch.ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
         wv_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         total_ff <= total_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
         wv_ff    <= wv_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      wn_ff    <= wn_in;
      wtrit_ff <= wtrit_in;
      wdone_ff <= wdone_in;
      wbad_ff  <= wbad_in;
      otrit_ff <= otrit_in;
      olast_ff <= olast_in;
      odone_ff <= odone_in;
      obad_ff  <= obad_in;
   end

   assign rsp_ch.valid        = ov_ff;
   assign rsp_ch.trit         = otrit_ff;
   assign rsp_ch.last_of_byte = olast_ff;
   assign rsp_ch.block_done   = odone_ff;
   assign rsp_ch.bad_byte     = obad_ff;

endmodule

// ===== hdl/ttu_checker.sv =====
// port-level checks of the ternary trit unpacker, bound to the top level
// depends on ttu_pkg and ternary_trit_unpacker_assert.svh
`include "ternary_trit_unpacker_assert.svh"

module ttu_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ttu_pkg::trit_type rsp_trit,
   input logic              rsp_last_of_byte,
   input logic              rsp_block_done,
   input logic              rsp_bad_byte
);

   // a stalled beat keeps its payload
   `TTU_ASSERT_NEXT(rsp_hold_chk, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_trit) && $stable(rsp_last_of_byte) && $stable(rsp_bad_byte), "rsp beat changed while stalled")

   // error beat is alone, carries no trit and never completes a block
   `TTU_ASSERT_IMP(bad_shape_chk, rsp_valid && rsp_bad_byte, rsp_last_of_byte && !rsp_block_done && rsp_trit == ttu_pkg::TRIT_ZERO, "malformed bad_byte beat")

   // block completion only lands on the final trit of a byte
   `TTU_ASSERT_IMP(done_last_chk, rsp_valid && rsp_block_done, rsp_last_of_byte, "block_done without last_of_byte")

   // a fresh run of beats starts once a taken byte has passed the work and output registers
   `TTU_ASSERT_IMP(rsp_cause_chk, $rose(rsp_valid), $past(req_valid && req_ready, 2), "rsp beat without an accepted byte")

endmodule

bind ternary_trit_unpacker ttu_checker u_ttu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_trit         (rsp_ch.trit),
   .rsp_last_of_byte (rsp_ch.last_of_byte),
   .rsp_block_done   (rsp_ch.block_done),
   .rsp_bad_byte     (rsp_ch.bad_byte)
);
